// ===== design/jpeg_app1_segment_finder_core_assert.svh =====
// Assertion macros for the segment finder.
`ifndef JPEG_APP1_SEGMENT_FINDER_CORE_ASSERT_SVH
`define JPEG_APP1_SEGMENT_FINDER_CORE_ASSERT_SVH

// Checked at every edge outside reset.
`define JASF_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked at every edge, reset included.
`define JASF_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== design/jasf_pkg.sv =====
package jasf_pkg;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic        found;
      logic [31:0] payload_offset;
      logic [15:0] payload_size;
   } rsp_type;

   typedef enum logic [2:0] {
      PH_START0,
      PH_START1,
      PH_MARK_FF,
      PH_MARKER,
      PH_LEN_HI,
      PH_LEN_LO,
      PH_BODY,
      PH_ABSORB
   } phase_type;

   localparam logic [7:0] BYTE_FF     = 8'hFF;
   localparam logic [7:0] MARKER_SOI  = 8'hD8;
   localparam logic [7:0] MARKER_SOS  = 8'hDA;
   localparam logic [7:0] MARKER_EOI  = 8'hD9;
   localparam logic [7:0] MARKER_APP1 = 8'hE1;
   localparam logic [7:0] MARKER_TEM  = 8'h01;
   localparam logic [7:0] MARKER_RST0 = 8'hD0;

   localparam logic NS_EXIF = 1'b0;
   localparam logic NS_XMP  = 1'b1;

   localparam logic [4:0] EXIF_LEN = 5'd6;
   localparam logic [4:0] XMP_LEN  = 5'd29;

   function automatic logic [4:0] ns_len(input logic sel);
      ns_len = (sel == NS_XMP) ? XMP_LEN : EXIF_LEN;
   endfunction

   // Expected namespace byte at a given index of the segment body.
   function automatic logic [7:0] ns_byte(input logic sel, input logic [4:0] idx);
      logic [7:0] b;
      b = 8'h00;
      if (sel == NS_EXIF) begin
         case (idx)
            5'd0:    b = 8'h45;
            5'd1:    b = 8'h78;
            5'd2:    b = 8'h69;
            5'd3:    b = 8'h66;
            default: b = 8'h00;
         endcase
      end else begin
         case (idx)
            5'd0:    b = 8'h68;
            5'd1:    b = 8'h74;
            5'd2:    b = 8'h74;
            5'd3:    b = 8'h70;
            5'd4:    b = 8'h3A;
            5'd5:    b = 8'h2F;
            5'd6:    b = 8'h2F;
            5'd7:    b = 8'h6E;
            5'd8:    b = 8'h73;
            5'd9:    b = 8'h2E;
            5'd10:   b = 8'h61;
            5'd11:   b = 8'h64;
            5'd12:   b = 8'h6F;
            5'd13:   b = 8'h62;
            5'd14:   b = 8'h65;
            5'd15:   b = 8'h2E;
            5'd16:   b = 8'h63;
            5'd17:   b = 8'h6F;
            5'd18:   b = 8'h6D;
            5'd19:   b = 8'h2F;
            5'd20:   b = 8'h78;
            5'd21:   b = 8'h61;
            5'd22:   b = 8'h70;
            5'd23:   b = 8'h2F;
            5'd24:   b = 8'h31;
            5'd25:   b = 8'h2E;
            5'd26:   b = 8'h30;
            5'd27:   b = 8'h2F;
            default: b = 8'h00;
         endcase
      end
      ns_byte = b;
   endfunction

endpackage

// ===== design/jasf_in_stage.sv =====
// Input holding register.
module jasf_in_stage (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  jasf_pkg::req_type req_data,
   input  logic             advance,
   output logic             held_valid,
   output jasf_pkg::req_type held_data
);

   logic              valid_ff, valid_in;
   jasf_pkg::req_type data_ff, data_in;

   assign req_ready  = !valid_ff || advance;
   assign held_valid = valid_ff;
   assign held_data  = data_ff;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (req_valid && req_ready) begin
         valid_in = 1'b1;
         data_in  = req_data;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

endmodule

// ===== design/jasf_out_stage.sv =====
// Result register.
module jasf_out_stage (
   input  logic             clock,
   input  logic             reset,
   input  logic             load_valid,
   input  jasf_pkg::rsp_type load_data,
   output logic             can_take,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output jasf_pkg::rsp_type rsp_data
);

   logic              valid_ff, valid_in;
   jasf_pkg::rsp_type data_ff, data_in;

   assign can_take  = !valid_ff || rsp_ready;
   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (can_take) begin
         valid_in = load_valid;
         if (load_valid) begin
            data_in = load_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

endmodule

// ===== design/jasf_parser.sv =====
// Marker walker: one byte per advance, result computed combinationally.
module jasf_parser #(
   parameter int POSITION_WIDTH = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  jasf_pkg::req_type  item,
   input  logic              ns_select,
   output logic              res_valid,
   output jasf_pkg::rsp_type  res_data
);

   `include "jpeg_app1_segment_finder_core_assert.svh"

   jasf_pkg::phase_type       phase_ff, phase_in;
   logic [POSITION_WIDTH-1:0] pos_ff, pos_in;
   logic [POSITION_WIDTH-1:0] start_ff, start_in;
   logic [15:0]               len_ff, len_in;
   logic [15:0]               rem_ff, rem_in;
   logic [4:0]                idx_ff, idx_in;
   logic [7:0]                marker_ff, marker_in;
   logic                      match_ff, match_in;

   logic [7:0]                b;
   logic [4:0]                nlen;
   logic [15:0]               len_full;
   logic [15:0]               body;
   logic [POSITION_WIDTH-1:0] pos_inc;
   logic [POSITION_WIDTH-1:0] off_full;
   logic                      settle;
   logic                      hit;
   logic                      standalone;

   assign b        = item.data_byte;
   assign nlen     = jasf_pkg::ns_len(ns_select);
   assign len_full = {len_ff[15:8], b};
   assign body     = len_ff - 16'd2;
   assign pos_inc  = pos_ff + POSITION_WIDTH'(1);
   assign off_full = start_ff + POSITION_WIDTH'(nlen);
   assign standalone = (b == jasf_pkg::MARKER_TEM) ||
                       (b >= jasf_pkg::MARKER_RST0 && b <= jasf_pkg::MARKER_SOI);

   always_comb begin
      phase_in  = phase_ff;
      start_in  = start_ff;
      len_in    = len_ff;
      rem_in    = rem_ff;
      idx_in    = idx_ff;
      marker_in = marker_ff;
      match_in  = match_ff;
      settle    = 1'b0;
      hit       = 1'b0;

      unique case (phase_ff)
         jasf_pkg::PH_START0: begin
            if (b == jasf_pkg::BYTE_FF) phase_in = jasf_pkg::PH_START1;
            else                        settle   = 1'b1;
         end
         jasf_pkg::PH_START1: begin
            if (b == jasf_pkg::MARKER_SOI) phase_in = jasf_pkg::PH_MARK_FF;
            else                           settle   = 1'b1;
         end
         jasf_pkg::PH_MARK_FF: begin
            if (b == jasf_pkg::BYTE_FF) phase_in = jasf_pkg::PH_MARKER;
            else                        settle   = 1'b1;
         end
         jasf_pkg::PH_MARKER: begin
            if (b == jasf_pkg::BYTE_FF) begin
               phase_in = jasf_pkg::PH_MARKER;
            end else if (standalone) begin
               phase_in = jasf_pkg::PH_MARK_FF;
            end else if (b == jasf_pkg::MARKER_SOS || b == jasf_pkg::MARKER_EOI) begin
               settle = 1'b1;
            end else begin
               marker_in = b;
               phase_in  = jasf_pkg::PH_LEN_HI;
            end
         end
         jasf_pkg::PH_LEN_HI: begin
            len_in   = {b, 8'h00};
            phase_in = jasf_pkg::PH_LEN_LO;
         end
         jasf_pkg::PH_LEN_LO: begin
            len_in = len_full;
            if (len_full < 16'd2) begin
               settle = 1'b1;
            end else begin
               rem_in   = len_full - 16'd2;
               idx_in   = '0;
               start_in = pos_inc;
               match_in = (marker_ff == jasf_pkg::MARKER_APP1) &&
                          ((len_full - 16'd2) >= {11'd0, nlen});
               phase_in = ((len_full - 16'd2) == 16'd0) ? jasf_pkg::PH_MARK_FF
                                                        : jasf_pkg::PH_BODY;
            end
         end
         jasf_pkg::PH_BODY: begin
            if (idx_ff < nlen) begin
               if (b != jasf_pkg::ns_byte(ns_select, idx_ff)) match_in = 1'b0;
               idx_in = idx_ff + 5'd1;
            end
            rem_in = rem_ff - 16'd1;
            if (rem_in == 16'd0) begin
               if (match_in && idx_in >= nlen && body >= {11'd0, nlen}) begin
                  hit    = 1'b1;
                  settle = 1'b1;
               end else begin
                  phase_in = jasf_pkg::PH_MARK_FF;
               end
            end
         end
         jasf_pkg::PH_ABSORB: begin
            phase_in = jasf_pkg::PH_ABSORB;
         end
         default: begin
            phase_in = jasf_pkg::PH_START0;
         end
      endcase

      if (settle) phase_in = jasf_pkg::PH_ABSORB;

      if (item.last_byte) begin
         phase_in  = jasf_pkg::PH_START0;
         len_in    = '0;
         rem_in    = '0;
         idx_in    = '0;
         marker_in = '0;
         match_in  = 1'b0;
      end
   end

   // Not-found results, settled or forced by the last byte, carry zeros.
   always_comb begin
      res_valid = settle || (item.last_byte && phase_ff != jasf_pkg::PH_ABSORB);
      res_data.found          = hit;
      res_data.payload_offset = hit ? 32'(off_full) : 32'd0;
      res_data.payload_size   = hit ? (body - {11'd0, nlen}) : 16'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= jasf_pkg::PH_START0;
         pos_ff    <= '0;
         start_ff  <= '0;
         len_ff    <= '0;
         rem_ff    <= '0;
         idx_ff    <= '0;
         marker_ff <= '0;
         match_ff  <= 1'b0;
      end else if (advance) begin
         phase_ff  <= phase_in;
         pos_ff    <= item.last_byte ? '0 : pos_inc;
         start_ff  <= start_in;
         len_ff    <= len_in;
         rem_ff    <= rem_in;
         idx_ff    <= idx_in;
         marker_ff <= marker_in;
         match_ff  <= match_in;
      end
   end

   `JASF_ASSERT_ALWAYS(a_reset_start, reset |=> (phase_ff == jasf_pkg::PH_START0 && pos_ff == '0), "parser not cleared by reset")
   `JASF_ASSERT(a_last_clears, (advance && item.last_byte) |=> (phase_ff == jasf_pkg::PH_START0 && pos_ff == '0), "stream state not cleared after last byte")
   `JASF_ASSERT(a_absorb_silent, (res_valid && phase_ff == jasf_pkg::PH_ABSORB) |-> item.last_byte, "result after answer already given")
   `JASF_ASSERT(a_miss_zero, (res_valid && !res_data.found) |-> (res_data.payload_offset == 32'd0 && res_data.payload_size == 16'd0), "not-found result with non-zero fields")
   `JASF_ASSERT(a_idx_bound, idx_ff <= jasf_pkg::XMP_LEN, "namespace compare index out of range")

endmodule

// ===== design/jpeg_app1_segment_finder_core.sv =====
// JPEG APP1 segment finder. Feed a JPEG file one byte per req_ transaction, in
// file order, with last_byte set on the final byte. The file must open FF D8;
// the block then walks the marker segments, skipping FF fill bytes and the
// standalone markers (01, D0..D8), and looks for the first APP1 segment that
// lies whole within the stream and whose body begins with the namespace chosen
// by csr_write_data (0: the six-byte Exif header, 1: the 29-byte XMP namespace
// including its closing NUL). Each stream yields exactly one rsp_ transaction:
// found with the offset and size of the payload that follows the namespace, or
// not found (all fields zero) on a bad start, a non-FF byte where a marker
// should stand, SOS, EOI, a length below two, or the end of the stream. Bytes
// after the answer are absorbed until last_byte, which also clears the parser.
// Rate: one byte per clock while the result register is empty or being read. A
// byte sits in the input register while its result is worked out combinationally,
// and the result register loads as the byte moves on; rsp_valid comes from the
// result register, so both registers lie between a req_ handshake and its rsp_ one.
// A result waiting in the result register holds the input register, and
// req_ready drops once both are full. Each byte needs only a marker compare,
// one namespace ROM lookup and counter updates.
// The namespace register may be written only while no transaction is in
// flight; it is not cleared by the end of a stream.
module jpeg_app1_segment_finder_core #(
   parameter int POSITION_WIDTH = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  jasf_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output jasf_pkg::rsp_type  rsp_data,
   input  logic              csr_write_enable,
   input  logic              csr_write_data
);

   // Namespace select register.
   logic ns_select_ff, ns_select_in;

   logic              held_valid;
   jasf_pkg::req_type held_data;
   logic              can_take;
   logic              advance;
   logic              res_valid;
   jasf_pkg::rsp_type res_data;

   assign ns_select_in = csr_write_enable ? csr_write_data : ns_select_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ns_select_ff <= jasf_pkg::NS_EXIF;
      end else begin
         ns_select_ff <= ns_select_in;
      end
   end

   // The held byte moves on whenever the result register can take whatever it
   // produces; bytes that produce nothing move on under the same rule.
   assign advance = held_valid && can_take;

   jasf_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .advance    (advance),
      .held_valid (held_valid),
      .held_data  (held_data)
   );

   jasf_parser #(
      .POSITION_WIDTH (POSITION_WIDTH)
   ) u_parser (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .item      (held_data),
      .ns_select (ns_select_ff),
      .res_valid (res_valid),
      .res_data  (res_data)
   );

   jasf_out_stage u_out_stage (
      .clock      (clock),
      .reset      (reset),
      .load_valid (advance && res_valid),
      .load_data  (res_data),
      .can_take   (can_take),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps

// Bench for the JPEG APP1 segment finder.
// Bytes go in one req_ transaction at a time. A scan model inside the bench
// follows the parser byte for byte and queues the answer that each stream
// should give. Every rsp_ transaction is checked against the oldest queued
// answer.
module tb_top;

   // Rough byte budget for each random pass (three passes).
   localparam int BYTES_PER_PASS = 500;
   // Input register plus result register, with some margin.
   localparam int SETTLE_CYCLES  = 4;

   // Namespace signatures, first byte in the top octet.
   localparam logic [8*6-1:0]  EXIF_SIG = 48'h45_78_69_66_00_00;
   localparam logic [8*29-1:0] XMP_SIG  =
      232'h687474703A2F2F6E732E_61646F62652E636F6D2F_7861702F312E302F00;

   localparam jasf_pkg::rsp_type NO_SEGMENT = '0;
   // Exif segment right after SOI: body starts at byte 6, payload at 12.
   localparam jasf_pkg::rsp_type EXIF_AT_12 = '{found: 1'b1, payload_offset: 32'd12,
                                                payload_size: 16'd0};

   typedef struct packed {
      logic [7:0]        b;
      logic              last;
      logic              pinned;   // answer typed in below rather than predicted
      jasf_pkg::rsp_type answer;
   } probe_row_type;

   // Directed streams, walked in order from reset (namespace is Exif).
   probe_row_type probe_rows [30] = '{
      // bad start; the trailing byte is absorbed and only closes the stream
      '{8'h00, 1'b0, 1'b1, NO_SEGMENT},
      '{8'hFF, 1'b1, 1'b0, NO_SEGMENT},
      // standalone TEM, then SOS ends the search
      '{8'hFF, 1'b0, 1'b0, NO_SEGMENT},
      '{8'hD8, 1'b0, 1'b0, NO_SEGMENT},
      '{8'hFF, 1'b0, 1'b0, NO_SEGMENT},
      '{8'h01, 1'b0, 1'b0, NO_SEGMENT},
      '{8'hFF, 1'b0, 1'b0, NO_SEGMENT},
      '{8'hDA, 1'b1, 1'b1, NO_SEGMENT},
      // non-FF byte where a marker belongs
      '{8'hFF, 1'b0, 1'b0, NO_SEGMENT},
      '{8'hD8, 1'b0, 1'b0, NO_SEGMENT},
      '{8'h44, 1'b1, 1'b1, NO_SEGMENT},
      // fill byte, then an APP1 with a length of one
      '{8'hFF, 1'b0, 1'b0, NO_SEGMENT},
      '{8'hD8, 1'b0, 1'b0, NO_SEGMENT},
      '{8'hFF, 1'b0, 1'b0, NO_SEGMENT},
      '{8'hFF, 1'b0, 1'b0, NO_SEGMENT},
      '{8'hE1, 1'b0, 1'b0, NO_SEGMENT},
      '{8'h00, 1'b0, 1'b0, NO_SEGMENT},
      '{8'h01, 1'b1, 1'b1, NO_SEGMENT},
      // smallest Exif hit: header only, empty payload, last on the final byte
      '{8'hFF, 1'b0, 1'b0, NO_SEGMENT},
      '{8'hD8, 1'b0, 1'b0, NO_SEGMENT},
      '{8'hFF, 1'b0, 1'b0, NO_SEGMENT},
      '{8'hE1, 1'b0, 1'b0, NO_SEGMENT},
      '{8'h00, 1'b0, 1'b0, NO_SEGMENT},
      '{8'h08, 1'b0, 1'b0, NO_SEGMENT},
      '{8'h45, 1'b0, 1'b0, NO_SEGMENT},
      '{8'h78, 1'b0, 1'b0, NO_SEGMENT},
      '{8'h69, 1'b0, 1'b0, NO_SEGMENT},
      '{8'h66, 1'b0, 1'b0, NO_SEGMENT},
      '{8'h00, 1'b0, 1'b0, NO_SEGMENT},
      '{8'h00, 1'b1, 1'b1, EXIF_AT_12}
   };

   logic              clock            = 1'b0;
   logic              reset            = 1'b1;
   logic              req_valid        = 1'b0;
   logic              req_ready;
   jasf_pkg::req_type req_data         = '0;
   logic              rsp_valid;
   logic              rsp_ready        = 1'b0;
   jasf_pkg::rsp_type rsp_data;
   logic              csr_write_enable = 1'b0;
   logic              csr_write_data   = 1'b0;

   // Side band travelling with the request, seen by the monitor only.
   logic              req_pinned        = 1'b0;
   jasf_pkg::rsp_type req_pinned_answer = '0;

   int send_idle_pct = 6;
   int rsp_stall_pct = 69;
   int fault_count   = 0;

   jasf_pkg::rsp_type pending_answers [$];
   logic [7:0]        file_bytes [$];

   // Scan model state, mirrors the parser.
   jasf_pkg::phase_type scan_phase;
   logic [31:0]         scan_pos;
   logic [15:0]         seg_len;
   logic [15:0]         seg_left;
   logic [4:0]          cmp_idx;
   logic [7:0]          seg_marker;
   logic                sig_ok;
   logic                answered;
   logic                ns_sel;     // shadow of the namespace register

   jpeg_app1_segment_finder_core u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic logic [4:0] sig_len(input logic sel);
      return (sel == jasf_pkg::NS_XMP) ? jasf_pkg::XMP_LEN : jasf_pkg::EXIF_LEN;
   endfunction

   function automatic logic [7:0] sig_byte(input logic sel, input logic [4:0] idx);
      int slot;
      slot = int'(sig_len(sel)) - 1 - int'(idx);
      if (sel == jasf_pkg::NS_XMP) return XMP_SIG[slot*8 +: 8];
      return EXIF_SIG[slot*8 +: 8];
   endfunction

   function automatic void restart_scan();
      scan_phase = jasf_pkg::PH_START0;
      scan_pos   = '0;
      seg_len    = '0;
      seg_left   = '0;
      cmp_idx    = '0;
      seg_marker = '0;
      sig_ok     = 1'b0;
      answered   = 1'b0;
   endfunction

   // One byte through the scan model; returns 1 when the byte gives an answer.
   function automatic bit scan_byte(input logic [7:0] b, input logic last,
                                    output jasf_pkg::rsp_type answer);
      logic        settle;
      bit          has_answer;
      logic [4:0]  nlen;
      logic [15:0] body;
      logic [31:0] start;
      settle     = 1'b0;
      has_answer = 1'b0;
      answer     = NO_SEGMENT;
      nlen       = sig_len(ns_sel);
      case (scan_phase)
         jasf_pkg::PH_START0: begin
            if (b == jasf_pkg::BYTE_FF) scan_phase = jasf_pkg::PH_START1;
            else settle = 1'b1;
         end
         jasf_pkg::PH_START1: begin
            if (b == jasf_pkg::MARKER_SOI) scan_phase = jasf_pkg::PH_MARK_FF;
            else settle = 1'b1;
         end
         jasf_pkg::PH_MARK_FF: begin
            if (b == jasf_pkg::BYTE_FF) scan_phase = jasf_pkg::PH_MARKER;
            else settle = 1'b1;
         end
         jasf_pkg::PH_MARKER: begin
            if (b == jasf_pkg::BYTE_FF) begin
               // fill byte, stay put
            end else if (b == jasf_pkg::MARKER_TEM ||
                         (b >= jasf_pkg::MARKER_RST0 && b <= jasf_pkg::MARKER_SOI)) begin
               scan_phase = jasf_pkg::PH_MARK_FF;
            end else if (b == jasf_pkg::MARKER_SOS || b == jasf_pkg::MARKER_EOI) begin
               settle = 1'b1;
            end else begin
               seg_marker = b;
               scan_phase = jasf_pkg::PH_LEN_HI;
            end
         end
         jasf_pkg::PH_LEN_HI: begin
            seg_len    = {b, 8'h00};
            scan_phase = jasf_pkg::PH_LEN_LO;
         end
         jasf_pkg::PH_LEN_LO: begin
            seg_len = {seg_len[15:8], b};
            if (seg_len < 16'd2) begin
               settle = 1'b1;
            end else begin
               seg_left   = seg_len - 16'd2;
               cmp_idx    = '0;
               sig_ok     = (seg_marker == jasf_pkg::MARKER_APP1) &&
                            (seg_left >= {11'd0, nlen});
               scan_phase = (seg_left == 16'd0) ? jasf_pkg::PH_MARK_FF : jasf_pkg::PH_BODY;
            end
         end
         jasf_pkg::PH_BODY: begin
            if (cmp_idx < nlen) begin
               if (b != sig_byte(ns_sel, cmp_idx)) sig_ok = 1'b0;
               cmp_idx = cmp_idx + 5'd1;
            end
            seg_left = seg_left - 16'd1;
            if (seg_left == 16'd0) begin
               body = seg_len - 16'd2;
               if (sig_ok && cmp_idx >= nlen && body >= {11'd0, nlen}) begin
                  start                 = scan_pos + 32'd1 - {16'd0, body};
                  answer.found          = 1'b1;
                  answer.payload_offset = start + {27'd0, nlen};
                  answer.payload_size   = body - {11'd0, nlen};
                  settle                = 1'b1;
               end else begin
                  scan_phase = jasf_pkg::PH_MARK_FF;
               end
            end
         end
         default: begin
            // answer given, soak up bytes until the last one
         end
      endcase

      if (settle) begin
         has_answer = 1'b1;
         answered   = 1'b1;
         scan_phase = jasf_pkg::PH_ABSORB;
      end
      scan_pos = scan_pos + 32'd1;

      if (last) begin
         // a stream that never settled still owes one not-found answer
         if (!answered) begin
            answer     = NO_SEGMENT;
            has_answer = 1'b1;
         end
         restart_scan();
      end
      return has_answer;
   endfunction

   task automatic check_answer(input jasf_pkg::rsp_type got);
      jasf_pkg::rsp_type want;
      if (pending_answers.size() == 0) begin
         $error("unexpected result: found %0d, payload_offset %0d, payload_size %0d",
                got.found, got.payload_offset, got.payload_size);
         fault_count++;
      end else begin
         want = pending_answers.pop_front();
         if (got.found !== want.found) begin
            $error("found: expected %0d, got %0d", want.found, got.found);
            fault_count++;
         end
         if (got.payload_offset !== want.payload_offset) begin
            $error("payload_offset: expected %0d, got %0d",
                   want.payload_offset, got.payload_offset);
            fault_count++;
         end
         if (got.payload_size !== want.payload_size) begin
            $error("payload_size: expected %0d, got %0d",
                   want.payload_size, got.payload_size);
            fault_count++;
         end
      end
   endtask

   // Monitor: everything sampled on the rising edge. The result is checked
   // before the byte accepted on the same edge is predicted; that byte's own
   // answer must still pass through the input and result registers anyway.
   always @(posedge clock) begin
      jasf_pkg::rsp_type predicted;
      bit                has_answer;
      if (reset) begin
         restart_scan();
         ns_sel = jasf_pkg::NS_EXIF;
      end else begin
         if (rsp_valid && rsp_ready) check_answer(rsp_data);
         if (req_valid && req_ready) begin
            has_answer = scan_byte(req_data.data_byte, req_data.last_byte, predicted);
            if (req_pinned) pending_answers.push_back(req_pinned_answer);
            else if (has_answer) pending_answers.push_back(predicted);
         end
         if (csr_write_enable) ns_sel = csr_write_data;
      end
   end

   // Receiver back-pressure, redrawn every falling edge.
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   // Drive one byte and hold it until the transaction completes. Valid is left
   // high on return so that back-to-back bytes never see a glitch; whoever
   // stops sending has to drop it.
   task automatic send_byte(input logic [7:0] b, input logic last,
                            input logic pinned, input jasf_pkg::rsp_type answer);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid         <= 1'b1;
      req_data          <= '{data_byte: b, last_byte: last};
      req_pinned        <= pinned;
      req_pinned_answer <= answer;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   // Stop sending and let the block drain. A byte with no answer may still be
   // in the pipe once the queue is empty, hence the extra cycles.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_answers.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_namespace(input logic sel);
      wait_idle();
      csr_write_enable <= 1'b1;
      csr_write_data   <= sel;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // Build one file into file_bytes. Mostly well-formed JPEG heads with random
   // segment mix; the rest is junk, or a well-formed head cut short.
   task automatic compose_file();
      int         kind;
      int         segs;
      int         n;
      int         body;
      int         nlen;
      int         flaw;
      logic [7:0] m;
      logic       sel;
      logic       cut_off;
      file_bytes.delete();
      kind = $urandom_range(99);
      if (kind < 20) begin
         if (kind < 10) begin
            file_bytes.push_back(jasf_pkg::BYTE_FF);
            file_bytes.push_back(jasf_pkg::MARKER_SOI);
         end
         repeat ($urandom_range(1, 10)) file_bytes.push_back(8'($urandom));
         return;
      end

      file_bytes.push_back(jasf_pkg::BYTE_FF);
      file_bytes.push_back(jasf_pkg::MARKER_SOI);
      segs    = $urandom_range(0, 4);
      cut_off = 1'b0;
      for (int s = 0; s < segs && !cut_off; s++) begin
         case ($urandom_range(9))
            0: begin
               // standalone marker, maybe behind fill bytes
               file_bytes.push_back(jasf_pkg::BYTE_FF);
               repeat ($urandom_range(0, 2)) file_bytes.push_back(jasf_pkg::BYTE_FF);
               n = $urandom_range(0, 9);
               file_bytes.push_back((n == 9) ? jasf_pkg::MARKER_TEM
                                             : jasf_pkg::MARKER_RST0 + 8'(n));
            end
            1, 2: begin
               // ordinary segment with a short random body
               m = 8'($urandom);
               if (m == jasf_pkg::BYTE_FF || m == jasf_pkg::MARKER_TEM ||
                   (m >= jasf_pkg::MARKER_RST0 && m <= jasf_pkg::MARKER_SOS))
                  m = 8'hFE;
               n = $urandom_range(0, 8);
               file_bytes.push_back(jasf_pkg::BYTE_FF);
               file_bytes.push_back(m);
               file_bytes.push_back(8'h00);
               file_bytes.push_back(8'(n + 2));
               repeat (n) file_bytes.push_back(8'($urandom));
            end
            3, 4, 5, 6, 7: begin
               // APP1: good, one corrupted namespace byte, too short for the
               // namespace, or the other namespace
               flaw = $urandom_range(9);
               sel  = (flaw == 9) ? !ns_sel : ns_sel;
               nlen = int'(sig_len(sel));
               body = nlen + $urandom_range(0, 16);
               if ($urandom_range(19) == 0) body += $urandom_range(200, 600);
               if (flaw == 8) body = $urandom_range(0, nlen - 1);
               file_bytes.push_back(jasf_pkg::BYTE_FF);
               file_bytes.push_back(jasf_pkg::MARKER_APP1);
               file_bytes.push_back(8'((body + 2) >> 8));
               file_bytes.push_back(8'(body + 2));
               for (int i = 0; i < body; i++)
                  file_bytes.push_back((i < nlen) ? sig_byte(sel, 5'(i)) : 8'($urandom));
               if (flaw == 6 || flaw == 7) begin
                  n = file_bytes.size() - body + $urandom_range(0, nlen - 1);
                  file_bytes[n] = file_bytes[n] ^ (8'd1 << $urandom_range(0, 7));
               end
            end
            8: begin
               // length far beyond the end of the file
               file_bytes.push_back(jasf_pkg::BYTE_FF);
               file_bytes.push_back(($urandom_range(1)) ? jasf_pkg::MARKER_APP1 : 8'hE2);
               file_bytes.push_back(8'($urandom_range(128, 255)));
               file_bytes.push_back(8'($urandom));
               repeat ($urandom_range(0, 6)) file_bytes.push_back(8'($urandom));
               cut_off = 1'b1;
            end
            default: begin
               // length of zero or one
               file_bytes.push_back(jasf_pkg::BYTE_FF);
               file_bytes.push_back(jasf_pkg::MARKER_APP1);
               file_bytes.push_back(8'h00);
               file_bytes.push_back(8'($urandom_range(0, 1)));
            end
         endcase
      end

      if (!cut_off) begin
         case ($urandom_range(9))
            0, 1, 2: begin
               file_bytes.push_back(jasf_pkg::BYTE_FF);
               file_bytes.push_back(jasf_pkg::MARKER_SOS);
               repeat ($urandom_range(0, 3)) file_bytes.push_back(8'($urandom));
            end
            3: begin
               file_bytes.push_back(jasf_pkg::BYTE_FF);
               file_bytes.push_back(jasf_pkg::MARKER_EOI);
            end
            4: file_bytes.push_back(8'($urandom_range(0, 254)));
            default: begin
               // just stop; the last byte closes the stream
            end
         endcase
      end

      if ($urandom_range(99) < 15) begin
         n = $urandom_range(1, file_bytes.size());
         while (file_bytes.size() > n) void'(file_bytes.pop_back());
      end
   endtask

   initial begin
      int sent;
      int streams;

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed streams, namespace still at its reset value
      foreach (probe_rows[i])
         send_byte(probe_rows[i].b, probe_rows[i].last,
                   probe_rows[i].pinned, probe_rows[i].answer);

      // three random passes: sender rarely idle / receiver often stalled,
      // then the reverse, then flat out
      for (int round = 0; round < 3; round++) begin
         write_namespace((round == 1) ? jasf_pkg::NS_EXIF : jasf_pkg::NS_XMP);
         case (round)
            0: begin
               send_idle_pct = 6;
               rsp_stall_pct = 69;
            end
            1: begin
               send_idle_pct = 69;
               rsp_stall_pct = 6;
            end
            default: begin
               send_idle_pct = 0;
               rsp_stall_pct = 0;
            end
         endcase
         sent    = 0;
         streams = 0;
         while (sent < BYTES_PER_PASS) begin
            // drain now and then and pick a fresh namespace
            if (streams % 8 == 7) write_namespace(1'($urandom_range(0, 1)));
            compose_file();
            foreach (file_bytes[i])
               send_byte(file_bytes[i], i == file_bytes.size() - 1, 1'b0, NO_SEGMENT);
            sent += file_bytes.size();
            streams++;
         end
      end

      wait_idle();
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (fault_count == 0 && pending_answers.size() == 0) begin
         $display("tb_top passed");
      end else begin
         $display("tb_top failed");
      end
      $finish;
   end

   // Hard stop: far beyond the slowest legal run.
   initial begin
      #10_000_000;
      $display("tb_top failed");
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+design
design/jasf_pkg.sv
design/jasf_in_stage.sv
design/jasf_out_stage.sv
design/jasf_parser.sv
design/jpeg_app1_segment_finder_core.sv
sim/tb_top.sv
